@@ hdl/sct_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, fixed-point constants and coefficients for the sine/cosine pipeline.
package sct_pkg;

   // Word sizes
   localparam int WORD_W     = 64;
   localparam int FRAC_W     = 58;
   localparam int HALF_W     = WORD_W / 2;
   localparam int ANGLE_W    = 32;
   localparam int VALUE_W    = 32;

   // Operation codes
   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   // Series length and multiplier depth
   localparam int TERMS_DEF  = 5;
   localparam int TERMS_MAX  = 8;
   localparam int MUL_LAT    = 5;
   localparam int SIDE_W_DEF = 64;

   // Angle constants in Q7.56
   localparam logic [WORD_W-1:0] HALF_PI_Q56 = 64'h01921FB54442D184;
   localparam logic [WORD_W-1:0] PI_Q56      = 64'h03243F6A8885A309;
   localparam logic [WORD_W-1:0] TAU_Q56     = 64'h06487ED5110B4612;

   // Range reduction: binary steps of 8, 4, 2, 1 turns, then one final turn
   localparam int RED_STEPS = 5;
   localparam logic [WORD_W-1:0] RED_SUB [RED_STEPS] = '{
      TAU_Q56 * 64'd8, TAU_Q56 * 64'd4, TAU_Q56 * 64'd2, TAU_Q56, TAU_Q56
   };
   localparam logic [WORD_W-1:0] RED_LIM [RED_STEPS] = '{
      PI_Q56 + TAU_Q56 * 64'd8, PI_Q56 + TAU_Q56 * 64'd4,
      PI_Q56 + TAU_Q56 * 64'd2, PI_Q56 + TAU_Q56, PI_Q56
   };

   // Taylor coefficients (-1)^k/(2k+1)! in Q.58, rounded to nearest
   localparam logic signed [WORD_W-1:0] COEF_Q58 [TERMS_MAX] = '{
      64'sd288230376151711744,
      -64'sd48038396025285291,
      64'sd2401919801264265,
      -64'sd57188566696768,
      64'sd794285648566,
      -64'sd7220778623,
      64'sd46287042,
      -64'sd220414
   };

endpackage

@@ hdl/sct_mul.sv @@
`timescale 1ns / 1ps
// Five-stage Q.58 signed multiplier with round to nearest, ties away from zero.
module sct_mul #(
   parameter int SIDE_W = sct_pkg::SIDE_W_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [sct_pkg::WORD_W-1:0]   in_a,
   input  logic signed [sct_pkg::WORD_W-1:0]   in_b,
   input  logic [SIDE_W-1:0]                   in_side,
   output logic                                out_valid,
   output logic signed [sct_pkg::WORD_W-1:0]   out_prod,
   output logic [SIDE_W-1:0]                   out_side
);

   localparam int W      = sct_pkg::WORD_W;
   localparam int HW     = sct_pkg::HALF_W;
   localparam int FW     = sct_pkg::FRAC_W;
   localparam int LAT    = sct_pkg::MUL_LAT;
   localparam int MID_W  = HW + 2;
   localparam int RND_LO = FW - HW;
   localparam int RND_W  = MID_W - RND_LO;
   localparam logic [MID_W-1:0] RND_BIT = MID_W'(1) << (RND_LO - 1);

   logic [LAT-1:0]    v_ff, v_in;
   logic [LAT-2:0]    neg_ff, neg_in;
   logic [SIDE_W-1:0] side_ff [LAT];

   logic [W-1:0]      a_u, b_u;
   logic [W-1:0]      ua_ff, ua_in, ub_ff, ub_in;
   logic [W-1:0]      p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [MID_W-1:0]  mid_ff, mid_in, rnd_sum;
   logic [W-1:0]      hs_ff, hs_in;
   logic [W-1:0]      q_ff, q_in;
   logic [W-1:0]      prod_ff, prod_in;

   assign a_u = in_a;
   assign b_u = in_b;

   // Control: valid and product sign travel with the data
   always_comb begin
      v_in   = {v_ff[LAT-2:0], in_valid};
      neg_in = {neg_ff[LAT-3:0], in_a[W-1] ^ in_b[W-1]};
   end

   // Stage 1: operand magnitudes
   always_comb begin
      ua_in = a_u[W-1] ? (~a_u + 1'b1) : a_u;
      ub_in = b_u[W-1] ? (~b_u + 1'b1) : b_u;
   end

   // Stage 2: four 32x32 partial products
   always_comb begin
      p0_in = ua_ff[HW-1:0] * ub_ff[HW-1:0];
      p1_in = ua_ff[HW-1:0] * ub_ff[W-1:HW];
      p2_in = ua_ff[W-1:HW] * ub_ff[HW-1:0];
      p3_in = ua_ff[W-1:HW] * ub_ff[W-1:HW];
   end

   // Stage 3: middle column and upper word sums
   always_comb begin
      mid_in = {2'b00, p0_ff[W-1:HW]} + {2'b00, p1_ff[HW-1:0]} + {2'b00, p2_ff[HW-1:0]};
      hs_in  = p3_ff + {{HW{1'b0}}, p1_ff[W-1:HW]} + {{HW{1'b0}}, p2_ff[W-1:HW]};
   end

   // Stage 4: round at bit 57 and take bits 121:58 of the full product
   always_comb begin
      rnd_sum = mid_ff + RND_BIT;
      q_in    = (hs_ff << (W - FW)) + {{(W-RND_W){1'b0}}, rnd_sum[MID_W-1:RND_LO]};
   end

   // Stage 5: apply sign
   always_comb begin
      prod_in = neg_ff[LAT-2] ? (~q_ff + 1'b1) : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      side_ff[0] <= in_side;
      for (int k = 1; k < LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p3_ff   <= p3_in;
      mid_ff  <= mid_in;
      hs_ff   <= hs_in;
      q_ff    <= q_in;
      prod_ff <= prod_in;
   end

   assign out_valid = v_ff[LAT-1];
   assign out_prod  = prod_ff;
   assign out_side  = side_ff[LAT-1];

endmodule

@@ hdl/sine_cosine_taylor.sv @@
`timescale 1ns / 1ps
// Pipelined fixed-point sine/cosine: range reduction, then a Horner-form odd Taylor series.
// The pipeline is a chain of TERMS + 1 five-stage multipliers plus front/back stages.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset (synchronous, active high) clears only the valid bits; items in flight are dropped.
module sine_cosine_taylor #(
   parameter int TERMS = sct_pkg::TERMS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic signed [sct_pkg::ANGLE_W-1:0]   req_angle,
   output logic                                 rsp_strobe,
   output logic signed [sct_pkg::VALUE_W-1:0]   rsp_value
);

   localparam int W       = sct_pkg::WORD_W;
   localparam int AW      = sct_pkg::ANGLE_W;
   localparam int VW      = sct_pkg::VALUE_W;
   localparam int NRED    = sct_pkg::RED_STEPS;
   localparam int MLAT    = sct_pkg::MUL_LAT;
   localparam int NSTEP   = TERMS - 1;
   localparam int ROUND_SH = sct_pkg::FRAC_W - (VW - 2);
   localparam int Q_W     = W + 1 - ROUND_SH;
   localparam int LAT     = (3 + NRED) + 2 * MLAT + NSTEP * (MLAT + 1) + 3;
   localparam logic [W:0]     ROUND_BIT = (W+1)'(1) << (ROUND_SH - 1);
   localparam logic [Q_W-1:0] Q_NEG_LIM = Q_W'(1) << (VW - 1);
   localparam logic [Q_W-1:0] Q_POS_LIM = Q_NEG_LIM - 1'b1;
   localparam logic [W-1:0]   MAG_MAX   = (W'(1) << (W - 2)) + sct_pkg::HALF_PI_Q56;

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Angle to Q7.56, cosine adds pi/2
   logic                x_v_ff;
   logic signed [W-1:0] x_ff, x_in;

   always_comb begin
      x_in = {req_angle[AW-1], req_angle, {(W-AW-1){1'b0}}};
      if (req_opcode == sct_pkg::OP_COSINE) begin
         x_in = x_in + $signed(sct_pkg::HALF_PI_Q56);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_v_ff <= 1'b0;
      end else begin
         x_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
   end

   // Magnitude and sign; the reduction works on the magnitude
   logic         red_v   [NRED+1];
   logic         red_neg [NRED+1];
   logic [W-1:0] red_m   [NRED+1];

   logic         mag_v_ff, mag_neg_ff;
   logic [W-1:0] mag_m_ff, mag_m_in;

   always_comb begin
      mag_m_in = x_ff[W-1] ? W'(-x_ff) : W'(x_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_v_ff <= 1'b0;
      end else begin
         mag_v_ff <= x_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_neg_ff <= x_ff[W-1];
      mag_m_ff   <= mag_m_in;
   end

   assign red_v[0]   = mag_v_ff;
   assign red_neg[0] = mag_neg_ff;
   assign red_m[0]   = mag_m_ff;

   // Reduction steps: take off a block of turns if above the step's limit
   for (genvar i = 0; i < NRED; i++) begin : g_red
      logic         step_v_ff, step_neg_ff;
      logic [W-1:0] step_m_ff, step_m_in;

      always_comb begin
         step_m_in = red_m[i];
         if (red_m[i] > sct_pkg::RED_LIM[i]) begin
            step_m_in = red_m[i] - sct_pkg::RED_SUB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            step_v_ff <= 1'b0;
         end else begin
            step_v_ff <= red_v[i];
         end
      end

      always_ff @(posedge clock) begin
         step_neg_ff <= red_neg[i];
         step_m_ff   <= step_m_in;
      end

      assign red_v[i+1]   = step_v_ff;
      assign red_neg[i+1] = step_neg_ff;
      assign red_m[i+1]   = step_m_ff;
   end

   // Back to signed Q.58: restore sign, scale by four
   logic                r_v_ff;
   logic signed [W-1:0] r_ff, r_in;
   logic [W-1:0]        r_scaled;

   always_comb begin
      r_scaled = red_m[NRED] << 2;
      r_in     = red_neg[NRED] ? $signed(~r_scaled + 1'b1) : $signed(r_scaled);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
      end else begin
         r_v_ff <= red_v[NRED];
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

   // x squared, with x carried alongside
   logic                h_v   [NSTEP+1];
   logic signed [W-1:0] h_x   [NSTEP+1];
   logic signed [W-1:0] h_x2  [NSTEP+1];
   logic signed [W-1:0] h_acc [NSTEP+1];
   logic [W-1:0]        sq_side;

   sct_mul #(
      .SIDE_W (W)
   ) u_mul_sq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_v_ff),
      .in_a      (r_ff),
      .in_b      (r_ff),
      .in_side   (r_ff),
      .out_valid (h_v[0]),
      .out_prod  (h_x2[0]),
      .out_side  (sq_side)
   );

   assign h_x[0]   = $signed(sq_side);
   assign h_acc[0] = sct_pkg::COEF_Q58[TERMS-1];

   // Horner steps: acc = coef + x^2 * acc
   for (genvar j = 1; j <= NSTEP; j++) begin : g_horner
      logic                m_v;
      logic signed [W-1:0] m_prod;
      logic [2*W-1:0]      m_side;
      logic                add_v_ff;
      logic signed [W-1:0] add_x_ff, add_x2_ff, add_acc_ff, add_acc_in;

      sct_mul #(
         .SIDE_W (2 * W)
      ) u_mul (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (h_v[j-1]),
         .in_a      (h_x2[j-1]),
         .in_b      (h_acc[j-1]),
         .in_side   ({h_x[j-1], h_x2[j-1]}),
         .out_valid (m_v),
         .out_prod  (m_prod),
         .out_side  (m_side)
      );

      always_comb begin
         add_acc_in = sct_pkg::COEF_Q58[TERMS-1-j] + m_prod;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            add_v_ff <= 1'b0;
         end else begin
            add_v_ff <= m_v;
         end
      end

      always_ff @(posedge clock) begin
         add_x_ff   <= $signed(m_side[2*W-1:W]);
         add_x2_ff  <= $signed(m_side[W-1:0]);
         add_acc_ff <= add_acc_in;
      end

      assign h_v[j]   = add_v_ff;
      assign h_x[j]   = add_x_ff;
      assign h_x2[j]  = add_x2_ff;
      assign h_acc[j] = add_acc_ff;
   end

   // Final multiply by x
   logic                fin_v;
   logic signed [W-1:0] fin_prod;

   sct_mul #(
      .SIDE_W (1)
   ) u_mul_fin (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_v[NSTEP]),
      .in_a      (h_x[NSTEP]),
      .in_b      (h_acc[NSTEP]),
      .in_side   (1'b0),
      .out_valid (fin_v),
      .out_prod  (fin_prod),
      .out_side  ()
   );

   // Q.58 to Q.30: magnitude, round half away, saturate and sign
   logic           f_v_ff, f_neg_ff;
   logic [W-1:0]   f_mag_ff, f_mag_in;
   logic           q_v_ff, q_neg_ff;
   logic [W:0]     q_sum;
   logic [Q_W-1:0] q_ff, q_in;
   logic           out_v_ff;
   logic [Q_W-1:0] q_sat;
   logic [VW-1:0]  out_value_ff, out_value_in;

   always_comb begin
      f_mag_in = fin_prod[W-1] ? W'(-fin_prod) : W'(fin_prod);
   end

   always_comb begin
      q_sum = {1'b0, f_mag_ff} + ROUND_BIT;
      q_in  = q_sum[W:ROUND_SH];
   end

   always_comb begin
      if (q_neg_ff) begin
         q_sat        = (q_ff > Q_NEG_LIM) ? Q_NEG_LIM : q_ff;
         out_value_in = ~q_sat[VW-1:0] + 1'b1;
      end else begin
         q_sat        = (q_ff > Q_POS_LIM) ? Q_POS_LIM : q_ff;
         out_value_in = q_sat[VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff   <= 1'b0;
         q_v_ff   <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         f_v_ff   <= fin_v;
         q_v_ff   <= f_v_ff;
         out_v_ff <= q_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_neg_ff     <= fin_prod[W-1];
      f_mag_ff     <= f_mag_in;
      q_neg_ff     <= f_neg_ff;
      q_ff         <= q_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_value  = $signed(out_value_ff);

   // A result is only ever shown for an item taken exactly one latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result strobe without a matching accepted item");

   // Scaled input always fits the span the binary reduction steps can cover
   a_red_span: assert property (@(posedge clock) disable iff (reset)
      red_v[0] |-> (red_m[0] <= MAG_MAX))
      else $error("angle magnitude beyond reduction span");

   // After the last reduction step the angle lies in (-pi, pi]
   a_red_range: assert property (@(posedge clock) disable iff (reset)
      red_v[NRED] |-> (($signed(red_m[NRED]) <= $signed(sct_pkg::PI_Q56)) &&
                       ($signed(red_m[NRED]) > -$signed(sct_pkg::PI_Q56))))
      else $error("reduced angle outside (-pi, pi]");

endmodule

@@ bench/sine_cosine_taylor_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined fixed-point sine/cosine block.
module sine_cosine_taylor_test;

   localparam int   ANGLE_W   = sct_pkg::ANGLE_W;
   localparam int   VALUE_W   = sct_pkg::VALUE_W;
   localparam int   TERMS_DEF = sct_pkg::TERMS_DEF;
   localparam int   TERMS_MAX = sct_pkg::TERMS_MAX;
   localparam int   LATENCY   = 6 * TERMS_DEF + 15;
   localparam int   RANDOM_ITEMS = 1250;

   typedef struct {
      logic                      op;
      logic signed [ANGLE_W-1:0] angle;
      logic signed [VALUE_W-1:0] value;
   } trig_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_opcode;
   logic signed [ANGLE_W-1:0] req_angle;
   logic                      rsp_strobe;
   logic signed [VALUE_W-1:0] rsp_value;

   trig_result_type pending_values [$];
   int              error_count;
   bit              gaps_on;

   // Angle landmarks in Q6.25, truncated from the Q7.56 constants
   logic signed [ANGLE_W-1:0] pi_q25;
   logic signed [ANGLE_W-1:0] half_pi_q25;
   logic signed [ANGLE_W-1:0] three_half_pi_q25;
   logic signed [ANGLE_W-1:0] three_pi_q25;

   sine_cosine_taylor #(.TERMS(TERMS_DEF)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_angle  (req_angle),
      .rsp_strobe (rsp_strobe),
      .rsp_value  (rsp_value)
   );

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // (a*b)/2^58 on magnitudes, round half away from zero, sign applied after
   function automatic logic signed [63:0] round_mul_q58(input logic signed [63:0] a,
                                                        input logic signed [63:0] b);
      logic [63:0]  mag_a;
      logic [63:0]  mag_b;
      logic [127:0] prod;
      logic [63:0]  r;
      mag_a = a[63] ? 64'(-a) : 64'(a);
      mag_b = b[63] ? 64'(-b) : 64'(b);
      prod  = {64'd0, mag_a} * {64'd0, mag_b};
      prod  = prod + (128'd1 << 57);
      r     = prod[121:58];
      if (a[63] != b[63])
         r = -r;
      return $signed(r);
   endfunction

   // Series coefficient (-1)^k/(2k+1)! in Q.58, magnitude rounded to nearest
   function automatic logic signed [63:0] series_coef(input int k);
      logic [63:0] fact;
      logic [63:0] mag;
      fact = 64'd1;
      for (int i = 2; i <= 2 * k + 1; i++)
         fact = fact * 64'(i);
      mag = ((64'd1 << 58) + fact / 64'd2) / fact;
      return (k % 2) ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [VALUE_W-1:0] predict_trig(
         input logic op, input logic signed [ANGLE_W-1:0] angle);
      logic signed [63:0] x;
      logic signed [63:0] x2;
      logic signed [63:0] acc;
      logic signed [63:0] res;
      logic [63:0]        mag;
      logic [63:0]        q;
      int                 n;
      // Q6.25 -> Q7.56, cosine as shifted sine
      x = {{32{angle[ANGLE_W-1]}}, angle};
      x = x <<< 31;
      if (op == sct_pkg::OP_COSINE)
         x = x + $signed(sct_pkg::HALF_PI_Q56);
      // Whole turns only; exactly +-pi stays put
      while (x > $signed(sct_pkg::PI_Q56))
         x = x - $signed(sct_pkg::TAU_Q56);
      while (x < -$signed(sct_pkg::PI_Q56))
         x = x + $signed(sct_pkg::TAU_Q56);
      x = x <<< 2;
      n = TERMS_DEF;
      if (n > TERMS_MAX) n = TERMS_MAX;
      if (n < 1) n = 1;
      // Horner evaluation of the odd polynomial
      x2  = round_mul_q58(x, x);
      acc = series_coef(n - 1);
      for (int k = n - 2; k >= 0; k--)
         acc = series_coef(k) + round_mul_q58(x2, acc);
      res = round_mul_q58(x, acc);
      // Q.58 -> Q2.30 with saturation
      mag = res[63] ? 64'(-res) : 64'(res);
      q   = (mag + (64'd1 << 27)) >> 28;
      if (res[63]) begin
         if (q > 64'h80000000) q = 64'h80000000;
         return $signed(32'(-q));
      end else begin
         if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
         return $signed(q[31:0]);
      end
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      trig_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_values.size() == 0) begin
            report_mismatch($sformatf("unexpected result value=%0d", rsp_value));
         end else begin
            want = pending_values.pop_front();
            if (rsp_value !== want.value)
               report_mismatch($sformatf("op=%0b angle=%0d: value got %0d want %0d",
                                         want.op, want.angle, rsp_value, want.value));
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, 9) : 0;
   endfunction

   // Idle for gap cycles, then present one item and hold it until taken
   task automatic send_item(input logic op, input logic signed [ANGLE_W-1:0] angle);
      trig_result_type item;
      int              gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_opcode <= op;
      req_angle  <= angle;
      do @(posedge clock); while (busy);
      item.op    = op;
      item.angle = angle;
      item.value = predict_trig(op, angle);
      pending_values.push_back(item);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_values.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      longint span;
      span = 8 * longint'(pi_q25);
      // half within four turns of zero, the rest anywhere in range
      if ($urandom_range(0, 1))
         return ANGLE_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
      return $signed($urandom());
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Field extremes for both operations
   task automatic test_extremes();
      send_item(sct_pkg::OP_SINE,   32'sd0);
      send_item(sct_pkg::OP_COSINE, 32'sd0);
      send_item(sct_pkg::OP_SINE,   32'sh80000000);
      send_item(sct_pkg::OP_COSINE, 32'sh80000000);
      send_item(sct_pkg::OP_SINE,   32'sh7FFFFFFF);
      send_item(sct_pkg::OP_COSINE, 32'sh7FFFFFFF);   // cosine near the top: offset must not wrap
      send_item(sct_pkg::OP_SINE,   32'sd1);
      send_item(sct_pkg::OP_COSINE, -32'sd1);
   endtask

   // Angles on either side of the reduction thresholds
   task automatic test_reduction_edges();
      send_item(sct_pkg::OP_SINE,   pi_q25);
      send_item(sct_pkg::OP_SINE,   pi_q25 + 1);
      send_item(sct_pkg::OP_SINE,   -pi_q25);
      send_item(sct_pkg::OP_SINE,   -pi_q25 - 1);
      send_item(sct_pkg::OP_SINE,   three_pi_q25);
      send_item(sct_pkg::OP_SINE,   three_pi_q25 + 1);
      send_item(sct_pkg::OP_COSINE, half_pi_q25);
      send_item(sct_pkg::OP_COSINE, half_pi_q25 + 1);
      send_item(sct_pkg::OP_COSINE, -three_half_pi_q25);
      send_item(sct_pkg::OP_COSINE, -three_half_pi_q25 - 1);
   endtask

   // Sender holds off until the pipeline is empty, then resumes
   task automatic test_drain_pause();
      repeat (3) send_item(1'($urandom_range(0, 1)), random_angle());
      wait_for_drain();
      repeat (3) send_item(1'($urandom_range(0, 1)), random_angle());
   endtask

   // Random items in bursts, some back to back, some with random gaps
   task automatic test_random_items(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0)
            gaps_on = ($urandom_range(0, 2) != 0);
         send_item(1'($urandom_range(0, 1)), random_angle());
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_opcode  = sct_pkg::OP_SINE;
      req_angle   = '0;
      error_count = 0;
      gaps_on     = 1'b1;
      pi_q25            = sct_pkg::PI_Q56[62:31];
      half_pi_q25       = sct_pkg::HALF_PI_Q56[62:31];
      three_half_pi_q25 = ANGLE_W'((sct_pkg::PI_Q56 + sct_pkg::HALF_PI_Q56) >> 31);
      three_pi_q25      = ANGLE_W'((sct_pkg::PI_Q56 + sct_pkg::TAU_Q56) >> 31);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_reduction_edges();
      test_drain_pause();
      test_random_items(RANDOM_ITEMS);

      wait_for_drain();
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0)
         $display("sine_cosine_taylor_test OK");
      else
         $display("sine_cosine_taylor_test NOT OK");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("sine_cosine_taylor_test NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/sct_pkg.sv
hdl/sct_mul.sv
hdl/sine_cosine_taylor.sv
bench/sine_cosine_taylor_test.sv
